// File: rtl/stkf_pkg.sv
// ============================================================================
// stkf_pkg: shared definitions for the streaming top-K frequency block
// Field widths, stream packing widths, parameter defaults and the control
// state type of the list update sequencer.
// ============================================================================
package stkf_pkg;

    // Field widths of the input and result beats.
    localparam int ID_W        = 10;
    localparam int K_CFG_W     = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    // Defaults for the top-level parameters.
    localparam int DEF_NUM_IDS     = 1024;
    localparam int DEF_MAX_K       = 10;
    localparam int DEF_COUNT_WIDTH = 16;

    // Reset value of the k_in_use register.
    localparam logic [K_CFG_W-1:0] K_RESET = 4'd10;

    // Update sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MATCH = 5'b00010,
        ST_KEY   = 5'b00100,
        ST_RANK  = 5'b01000,
        ST_APPLY = 5'b10000
    } upd_state_t;

endpackage

// File: rtl/streaming_top_k_frequency.sv
// ============================================================================
// streaming_top_k_frequency: top-K frequent item tracker
// Counts item identifiers in a table memory and keeps a ranked list of the
// most frequent ones, reporting the list before every count.
// ============================================================================
// Each input beat carries one item identifier. The block first answers with
// the current ranked list (highest count first, lower identifier first on a
// tie), one output beat per rank, the final beat of the run marked by tlast;
// an empty list gives no beats. Then the item is counted in a per-identifier
// table in a memory with one write port and one registered read port (read
// at acceptance, written back in the following cycle), and the ranked list,
// a row of MAX_K register cells, is updated through the match, key, rank and
// apply states. The report drains one beat per cycle while the output is not
// stalled, from a snapshot of the list, as the update runs beside it; a new
// item is accepted only once both report and update are done. After reset a
// clearing pass writes zero to the count table one entry per cycle, during
// which no item is accepted; configuration writes are taken at any time.
module streaming_top_k_frequency #(
    parameter int NUM_IDS     = stkf_pkg::DEF_NUM_IDS,
    parameter int MAX_K       = stkf_pkg::DEF_MAX_K,
    parameter int COUNT_WIDTH = stkf_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel: k_in_use.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stkf_pkg::K_CFG_W-1:0]      cfg_data,
    // Input stream. tdata: [9:0] item_id, rest zero.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stkf_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Output stream. tdata: [9:0] query_id, [19:10] recommended_id, rest zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stkf_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast
);
    import stkf_pkg::*;

    localparam int AW = $clog2(NUM_IDS);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_IDS - 1);

    // Count table memory and its registered read port.
    logic [CW-1:0] cnt_mem [NUM_IDS];
    logic [CW-1:0] mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Control state.
    upd_state_t        state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_done_reg, clr_done_next;
    logic [K_CFG_W-1:0] k_reg, k_next;
    logic [KW-1:0]     fill_reg, fill_next;
    logic [KW-1:0]     rem_reg, rem_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state.
    logic [ID_W-1:0]   top_id_reg  [MAX_K];
    logic [ID_W-1:0]   top_id_next [MAX_K];
    logic [CW-1:0]     top_cnt_reg  [MAX_K];
    logic [CW-1:0]     top_cnt_next [MAX_K];
    logic [ID_W-1:0]   snap_reg  [MAX_K];
    logic [ID_W-1:0]   snap_next [MAX_K];
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ID_W-1:0]   out_query_reg, out_query_next;
    logic [ID_W-1:0]   out_rec_reg, out_rec_next;
    logic              out_last_reg, out_last_next;
    logic [MAX_K-1:0]  match_reg, match_next;
    logic [MAX_K-1:0]  le_reg, le_next;
    logic [MAX_K-1:0]  rank_reg, rank_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     hit_reg, hit_next;
    logic [CW-1:0]     key_cnt_reg, key_cnt_next;

    // Helpers.
    logic [ID_W-1:0]   in_id;
    logic              in_accept;
    logic              in_range;
    logic [KW-1:0]     k_eff;
    logic [KW-1:0]     fill_trunc;
    logic              out_load;
    logic [CW-1:0]     sel_cnt;
    logic              evict;
    logic              do_upd;
    logic              insert_new;

    assign in_id     = s_tdata[ID_W-1:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = clr_done_reg && (state_reg == ST_IDLE) && (rem_reg == '0);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (int'(in_id) < NUM_IDS);
    assign mem_raddr = AW'(in_id);
    assign out_load  = (rem_reg != '0) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2 * ID_W){1'b0}}, out_rec_reg, out_query_reg};

    // Effective k: zero acts as one, values above MAX_K act as MAX_K.
    always_comb
    begin
        if (k_reg == '0)
        begin
            k_eff = KW'(1);
        end
        else if (int'(k_reg) > MAX_K)
        begin
            k_eff = KW'(MAX_K);
        end
        else
        begin
            k_eff = KW'(k_reg);
        end
        fill_trunc = (fill_reg < k_eff) ? fill_reg : k_eff;
    end

    // Count table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept)
        begin
            mem_rdata_reg <= cnt_mem[mem_raddr];
        end
    end

    // Memory write: clearing pass after reset, else the counted update.
    always_comb
    begin
        if (!clr_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_MATCH);
            mem_waddr = AW'(id_reg);
            mem_wdata = hit_next;
        end
    end

    // Selected list count of the matching entry (at most one matches).
    always_comb
    begin
        sel_cnt = '0;
        for (int i = 0; i < MAX_K; i++)
        begin
            sel_cnt = sel_cnt | (top_cnt_reg[i] & {CW{match_reg[i]}});
        end
    end

    // Update decision for the apply step.
    always_comb
    begin
        evict = 1'b0;
        for (int i = 0; i < MAX_K; i++)
        begin
            if ((KW'(i) + KW'(1) == fill_reg) && !rank_reg[i])
            begin
                evict = 1'b1;
            end
        end
        insert_new = !found_reg && (fill_reg < k_eff);
        do_upd     = found_reg || insert_new || (!found_reg && (fill_reg == k_eff) && evict);
    end

    // Next-state logic of the sequencer, the list cells and the report.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_done_next  = clr_done_reg;
        k_next         = k_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_query_next = out_query_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        id_next        = id_reg;
        match_next     = match_reg;
        le_next        = le_reg;
        rank_next      = rank_reg;
        found_next     = found_reg;
        hit_next       = (mem_rdata_reg == CNT_MAX) ? CNT_MAX : mem_rdata_reg + 1'b1;
        key_cnt_next   = key_cnt_reg;
        for (int i = 0; i < MAX_K; i++)
        begin
            top_id_next[i]  = top_id_reg[i];
            top_cnt_next[i] = top_cnt_reg[i];
            snap_next[i]    = snap_reg[i];
        end

        // Clearing pass over the count table.
        if (!clr_done_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_done_next = 1'b1;
            end
        end

        // Configuration write.
        if (cfg_valid && cfg_ready)
        begin
            k_next = cfg_data;
        end

        // Report drain: a beat leaves the snapshot into the output register.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_query_next = id_reg;
            out_rec_next   = snap_reg[0];
            out_last_next  = (rem_reg == KW'(1));
            rem_next       = rem_reg - 1'b1;
            for (int i = 0; i < MAX_K - 1; i++)
            begin
                snap_next[i] = snap_reg[i + 1];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    // Snapshot the list for the report, cut the fill to k.
                    for (int i = 0; i < MAX_K; i++)
                    begin
                        snap_next[i] = top_id_reg[i];
                    end
                    rem_next       = fill_trunc;
                    fill_next      = fill_trunc;
                    id_next        = in_id;
                    if (in_range)
                    begin
                        state_next = ST_MATCH;
                    end
                end
            end
            ST_MATCH:
            begin
                // Look the item up in the list; the memory writes the new count.
                for (int i = 0; i < MAX_K; i++)
                begin
                    match_next[i] = (KW'(i) < fill_reg) && (top_id_reg[i] == id_reg);
                end
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                // Form the entry to insert and the end of the range to shift.
                found_next = |match_reg;
                if (|match_reg)
                begin
                    key_cnt_next = (sel_cnt == CNT_MAX) ? CNT_MAX : sel_cnt + 1'b1;
                end
                else
                begin
                    key_cnt_next = hit_reg;
                end
                for (int i = 0; i < MAX_K; i++)
                begin
                    if (|match_reg)
                    begin
                        le_next[i] = |(match_reg >> i);
                    end
                    else if (fill_reg < k_eff)
                    begin
                        le_next[i] = (KW'(i) <= fill_reg);
                    end
                    else
                    begin
                        le_next[i] = (KW'(i) < fill_reg);
                    end
                end
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                // Flag the entries that rank before the new entry.
                for (int i = 0; i < MAX_K; i++)
                begin
                    rank_next[i] = (KW'(i) < fill_reg) &&
                                   ((top_cnt_reg[i] > key_cnt_reg) ||
                                    ((top_cnt_reg[i] == key_cnt_reg) &&
                                     (top_id_reg[i] < id_reg)));
                end
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // Each cell keeps, takes the new entry or takes its upper neighbor.
                if (do_upd)
                begin
                    for (int i = 0; i < MAX_K; i++)
                    begin
                        if (le_reg[i] && !rank_reg[i])
                        begin
                            if (i == 0)
                            begin
                                top_id_next[i]  = id_reg;
                                top_cnt_next[i] = key_cnt_reg;
                            end
                            else if (rank_reg[(i == 0) ? 0 : i - 1])
                            begin
                                top_id_next[i]  = id_reg;
                                top_cnt_next[i] = key_cnt_reg;
                            end
                            else
                            begin
                                top_id_next[i]  = top_id_reg[(i == 0) ? 0 : i - 1];
                                top_cnt_next[i] = top_cnt_reg[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                end
                if (insert_new)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_addr_reg  <= '0;
            clr_done_reg  <= 1'b0;
            k_reg         <= K_RESET;
            fill_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_done_reg  <= clr_done_next;
            k_reg         <= k_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            top_id_reg[i]  <= top_id_next[i];
            top_cnt_reg[i] <= top_cnt_next[i];
            snap_reg[i]    <= snap_next[i];
        end
        id_reg        <= id_next;
        out_query_reg <= out_query_next;
        out_rec_reg   <= out_rec_next;
        out_last_reg  <= out_last_next;
        match_reg     <= match_next;
        le_reg        <= le_next;
        rank_reg      <= rank_next;
        found_reg     <= found_next;
        if (state_reg == ST_MATCH)
        begin
            hit_reg <= hit_next;
        end
        key_cnt_reg   <= key_cnt_next;
    end

    // The counted update never starts before the clearing pass is over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |-> clr_done_reg)
        else $error("count update during clearing pass");

    // An identifier appears at most once in the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> $onehot0(match_reg))
        else $error("identifier found at several list ranks");

    // The fill never passes the list depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_K)
        else $error("list fill beyond depth");

    // An update grows the list by at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |=> (int'(fill_reg) <= int'($past(fill_reg)) + 1))
        else $error("list fill grew by more than one");

    // A waiting output beat holds its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

// File: dv/streaming_top_k_frequency_tb.sv
// ----------------------------------------------------------------------------
// streaming_top_k_frequency_tb: self-checking bench for the top-K tracker
// Drives item identifiers into the input stream and checks every ranked-list
// beat on the output stream against a cycle-free model of the hit counts
// and the ranked list. The k_in_use register is changed between phases,
// including the out-of-range settings and a cut of a full list.
// ----------------------------------------------------------------------------
module streaming_top_k_frequency_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stkf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // Cycles to let pass after the last expected beat, so that an update
    // that causes no beat has surely finished.
    localparam int DRAIN_CYCLES = 24;
    localparam int HOT_IDS      = 12;

    typedef logic [ID_W-1:0]            id_t;
    typedef logic [DEF_COUNT_WIDTH-1:0] count_t;

    // One expected beat of a ranked-list report.
    typedef struct packed {
        id_t  query_id;
        id_t  recommended_id;
        logic last;
    } rank_beat_t;

    // Ranked-list model and store of expected report beats.
    class topk_scoreboard;
        count_t      hit_counts [DEF_NUM_IDS];
        id_t         top_ids [DEF_MAX_K];
        count_t      top_counts [DEF_MAX_K];
        int unsigned top_fill;
        logic [K_CFG_W-1:0] k_reg;
        rank_beat_t  rank_q [$];
        int unsigned mismatches;
        int unsigned beats_checked;

        function new();
            foreach (hit_counts[i]) hit_counts[i] = '0;
            foreach (top_ids[i])
            begin
                top_ids[i]    = '0;
                top_counts[i] = '0;
            end
            top_fill      = 0;
            k_reg         = K_RESET;
            mismatches    = 0;
            beats_checked = 0;
        endfunction

        function void set_k(logic [K_CFG_W-1:0] value);
            k_reg = value;
        endfunction

        function int unsigned pending();
            return rank_q.size();
        endfunction

        // Zero acts as one and anything above the list size acts as the size.
        function int unsigned k_limit();
            int unsigned k;
            k = k_reg;
            if (k < 1) k = 1;
            if (k > DEF_MAX_K) k = DEF_MAX_K;
            return k;
        endfunction

        // Higher count first, lower identifier first on equal counts.
        function bit ranks_ahead(id_t ida, count_t ca, id_t idb, count_t cb);
            if (ca != cb) return ca > cb;
            return ida < idb;
        endfunction

        function count_t sat_inc(count_t c);
            return (c == '1) ? c : c + 1'b1;
        endfunction

        // Move the entry at pos toward the front while it beats its neighbor.
        function void promote(int unsigned pos);
            id_t    tid;
            count_t tcnt;
            while (pos > 0 && ranks_ahead(top_ids[pos], top_counts[pos],
                                          top_ids[pos-1], top_counts[pos-1]))
            begin
                tid              = top_ids[pos];
                tcnt             = top_counts[pos];
                top_ids[pos]     = top_ids[pos-1];
                top_counts[pos]  = top_counts[pos-1];
                top_ids[pos-1]   = tid;
                top_counts[pos-1] = tcnt;
                pos--;
            end
        endfunction

        // Queue the report for an accepted item, then count it.
        function void note_item(id_t id);
            int unsigned k;
            int unsigned n;
            int unsigned hit_pos;
            bit          found;
            count_t      c;
            rank_beat_t  beat;
            k = k_limit();
            n = (top_fill < k) ? top_fill : k;
            for (int unsigned r = 0; r < n; r++)
            begin
                beat.query_id       = id;
                beat.recommended_id = top_ids[r];
                beat.last           = (r + 1 == n);
                rank_q.push_back(beat);
            end

            // A lowered k cuts the list before the update.
            if (top_fill > k) top_fill = k;

            c = sat_inc(hit_counts[id]);
            hit_counts[id] = c;

            found   = 1'b0;
            hit_pos = 0;
            for (int unsigned p = 0; p < top_fill; p++)
            begin
                if (!found && top_ids[p] == id)
                begin
                    found   = 1'b1;
                    hit_pos = p;
                end
            end

            if (found)
            begin
                top_counts[hit_pos] = sat_inc(top_counts[hit_pos]);
                promote(hit_pos);
            end
            else if (top_fill < k)
            begin
                top_ids[top_fill]    = id;
                top_counts[top_fill] = c;
                promote(top_fill);
                top_fill++;
            end
            else if (top_fill > 0)
            begin
                hit_pos = top_fill - 1;
                if (ranks_ahead(id, c, top_ids[hit_pos], top_counts[hit_pos]))
                begin
                    top_ids[hit_pos]    = id;
                    top_counts[hit_pos] = c;
                    promote(hit_pos);
                end
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        // Compare one accepted output beat with the oldest expectation.
        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            rank_beat_t exp_beat;
            beats_checked++;
            if (rank_q.size() == 0)
            begin
                report($sformatf("unexpected beat tdata=%h tlast=%b", tdata, tlast));
                return;
            end
            exp_beat = rank_q.pop_front();
            if (tdata[ID_W-1:0] !== exp_beat.query_id)
                report($sformatf("query_id %0d, expected %0d",
                                 tdata[ID_W-1:0], exp_beat.query_id));
            if (tdata[2*ID_W-1:ID_W] !== exp_beat.recommended_id)
                report($sformatf("recommended_id %0d, expected %0d (query %0d)",
                                 tdata[2*ID_W-1:ID_W], exp_beat.recommended_id,
                                 exp_beat.query_id));
            if (tlast !== exp_beat.last)
                report($sformatf("tlast %b, expected %b (query %0d)",
                                 tlast, exp_beat.last, exp_beat.query_id));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [K_CFG_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [9:0] item_id, rest zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [9:0] query_id, [19:10] recommended_id
    logic                   m_tlast;

    topk_scoreboard sb;
    bit             tx_idle_en = 1'b1;
    bit             rx_idle_en = 1'b1;
    int             rx_hold = 0;
    int unsigned    items_sent = 0;

    // Directed items: first item on an empty list, field extremes, ties,
    // a full list with entries pushed out, and a climb to the top.
    id_t directed_ids [20] = '{10'd0, 10'd1023, 10'd1023, 10'h155, 10'h2AA,
                               10'h2AA, 10'd9, 10'd8, 10'd7, 10'd6,
                               10'd5, 10'd4, 10'd3, 10'd1000, 10'd1000,
                               10'd0, 10'd0, 10'd0, 10'd1, 10'd1022};

    streaming_top_k_frequency u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Gap length: drawn from a short range with 85 percent chance, else from a long range.
    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Output side: check accepted beats and stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold  <= rx_hold - 1;
            end
            else if (rx_idle_en && $urandom_range(0, 99) < 25)
            begin
                m_tready <= 1'b0;
                rx_hold  <= stall_len() - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted.
    task automatic send_item(id_t id);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 40) ? stall_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-ID_W){1'b0}}, id};
        do @(posedge clk); while (!s_tready);
        sb.note_item(id);
        items_sent++;
    endtask

    // Drop the input stream, then wait for every report and a drain pause.
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write k_in_use while the block is idle.
    task automatic write_k(logic [K_CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_k(value);
    endtask

    // Random items drawn mostly from a small hot set so that counts build up.
    task automatic run_random_phase(logic [K_CFG_W-1:0] k, int n_items);
        id_t hot [HOT_IDS];
        id_t id;
        foreach (hot[i]) hot[i] = id_t'($urandom_range(0, 1023));
        write_k(k);
        repeat (n_items)
        begin
            if ($urandom_range(0, 99) < 70)
                id = hot[$urandom_range(0, HOT_IDS - 1)];
            else
                id = id_t'($urandom_range(0, 1023));
            send_item(id);
        end
        finish_phase();
    endtask

    // Main sequence.
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the full list size.
        write_k(4'd10);
        foreach (directed_ids[i]) send_item(directed_ids[i]);
        finish_phase();

        // Lower k below the fill, then the two out-of-range settings.
        write_k(4'd3);
        send_item(10'd512);
        send_item(10'd1023);
        finish_phase();
        write_k(4'd0);
        send_item(10'd2);
        send_item(10'h2AA);
        finish_phase();
        write_k(4'd15);
        send_item(10'd100);
        send_item(10'd200);
        send_item(10'd300);
        finish_phase();

        // Random part over several settings; one phase without idling.
        run_random_phase(4'd1, 40);
        run_random_phase(4'd10, 40);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_phase(4'd7, 40);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_random_phase(4'd15, 40);
        run_random_phase(K_CFG_W'($urandom_range(0, 15)), 40);
        run_random_phase(K_CFG_W'($urandom_range(0, 15)), 40);

        // A short closing phase with two ranks reported.
        write_k(4'd2);
        send_item(10'h155);
        send_item(10'd1023);
        send_item(10'd0);
        send_item(10'h155);
        finish_phase();

        $display("Sent %0d items and checked %0d report beats.", items_sent,
                 sb.beats_checked);
        $display("Covered k from 0 to 15, a cut list, ties and evictions from a full list.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit.
    initial
    begin
        #25ms;
        $display("Timeout with %0d report beats outstanding.", sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
